/* hw/rtl/dwc_pkg.sv */
package dwc_pkg;

  localparam int MAX_STATES    = 64;
  localparam int ALPHABET_SIZE = 256;

  localparam int ST_W       = $clog2(MAX_STATES);
  localparam int SYM_W      = $clog2(ALPHABET_SIZE);
  localparam int TBL_AW     = ST_W + SYM_W;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int CNT_AW     = ST_W + 1;
  localparam int CNT_DEPTH  = 1 << CNT_AW;
  localparam int FIELD_ST_W = 7;
  localparam int FIELD_SY_W = 8;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 30;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [CNT_W-1:0] PRIME_MOD = 30'd1000000007;
  localparam logic [SYM_W-1:0] SYM_LAST  = SYM_W'(ALPHABET_SIZE - 1);

  localparam logic [1:0] REG_WORD_LENGTH = 2'd0;
  localparam logic [1:0] REG_START_STATE = 2'd1;
  localparam logic [1:0] REG_STATE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ACT_SET_TRANS  = 2'd0,
    ACT_MARK_FINAL = 2'd1,
    ACT_RUN        = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_FETCH,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic                  en;
    logic [TBL_AW-1:0]     addr;
    logic [FIELD_ST_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [CNT_AW-1:0] addr;
    logic [CNT_W-1:0]  data;
  } cnt_wr_t;

  typedef struct packed {
    logic add;
    logic last;
  } acc_ctl_t;

endpackage

/* hw/rtl/dwc_trans_mem.sv */
module dwc_trans_mem (
  input  logic                           clk_i,
  input  dwc_pkg::tbl_wr_t               wr_i,
  input  logic [dwc_pkg::TBL_AW-1:0]     rd_addr_i,
  output logic [dwc_pkg::FIELD_ST_W-1:0] rd_data_o
);
  import dwc_pkg::*;

  logic [FIELD_ST_W-1:0] mem [TBL_DEPTH];
  logic [FIELD_ST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/dwc_count_mem.sv */
module dwc_count_mem (
  input  logic                      clk_i,
  input  dwc_pkg::cnt_wr_t          wr_i,
  input  logic [dwc_pkg::CNT_AW-1:0] rd_addr_i,
  output logic [dwc_pkg::CNT_W-1:0]  rd_data_o
);
  import dwc_pkg::*;

  logic [CNT_W-1:0] mem [CNT_DEPTH];
  logic [CNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/dwc_mod_acc.sv */
module dwc_mod_acc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dwc_pkg::acc_ctl_t        ctl_i,
  input  logic [dwc_pkg::CNT_W-1:0] cnt_i,
  output logic [dwc_pkg::CNT_W-1:0] sum_o
);
  import dwc_pkg::*;

  logic [CNT_W-1:0] acc_q, acc_d;
  logic [CNT_W:0]   sum_raw;
  logic [CNT_W:0]   sum_red;

  // modular add, both operands below the prime
  always_comb begin
    sum_raw = {1'b0, acc_q} + {1'b0, (ctl_i.add ? cnt_i : '0)};
    if (sum_raw >= {1'b0, PRIME_MOD}) begin
      sum_red = sum_raw - {1'b0, PRIME_MOD};
    end else begin
      sum_red = sum_raw;
    end
    sum_o = sum_red[CNT_W-1:0];
    acc_d = ctl_i.last ? '0 : sum_red[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

/* hw/rtl/dwc_seq.sv */
module dwc_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] from_state_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] to_state_i,
  input  logic [dwc_pkg::FIELD_SY_W-1:0] symbol_i,
  input  logic [dwc_pkg::LEN_W-1:0]      word_length_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] start_state_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] state_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dwc_pkg::CNT_W-1:0]      word_count_o,
  output dwc_pkg::tbl_wr_t               tbl_wr_o,
  output logic [dwc_pkg::TBL_AW-1:0]     tbl_rd_addr_o,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] tbl_rd_data_i,
  output dwc_pkg::cnt_wr_t               cnt_wr_o,
  output logic [dwc_pkg::CNT_AW-1:0]     cnt_rd_addr_o,
  input  logic [dwc_pkg::CNT_W-1:0]      cnt_rd_data_i,
  output dwc_pkg::acc_ctl_t              acc_ctl_o,
  input  logic [dwc_pkg::CNT_W-1:0]      acc_sum_i
);
  import dwc_pkg::*;

  seq_state_e            state_q, state_d;
  logic [ST_W-1:0]       s_q, s_d;
  logic [SYM_W-1:0]      c_q, c_d;
  logic [LEN_W-1:0]      step_q, step_d;
  logic                  bank_q, bank_d;
  logic [MAX_STATES-1:0] final_q, final_d;
  logic                  p1_v_q, p1_last_q, p2_add_q, p2_last_q;
  logic                  p1_v_d, p1_last_d, p2_add_d, p2_last_d;
  logic [CNT_W-1:0]      res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic [CNT_W-1:0]      out_count_q;
  logic                  load_out;
  logic                  issue;

  logic [FIELD_ST_W-1:0] n_eff;
  logic                  start_ok;
  logic                  from_ok;
  logic                  to_ok;
  logic                  sym_ok;
  logic [ST_W-1:0]       from_idx;
  logic [ST_W-1:0]       start_idx;
  logic [ST_W-1:0]       tgt_idx;
  logic                  tgt_ok;
  logic                  last_state;

  always_comb begin
    if (32'(state_count_i) > MAX_STATES) begin
      n_eff = FIELD_ST_W'(MAX_STATES);
    end else begin
      n_eff = state_count_i;
    end
    start_ok   = (start_state_i != '0) && (start_state_i <= n_eff);
    from_ok    = (from_state_i != '0) && (32'(from_state_i) <= MAX_STATES);
    to_ok      = (to_state_i != '0) && (32'(to_state_i) <= MAX_STATES);
    sym_ok     = 32'(symbol_i) < ALPHABET_SIZE;
    from_idx   = ST_W'(from_state_i - 1'b1);
    start_idx  = ST_W'(start_state_i - 1'b1);
    tgt_idx    = ST_W'(tbl_rd_data_i - 1'b1);
    tgt_ok     = (tbl_rd_data_i != '0) && (tbl_rd_data_i <= n_eff);
    last_state = FIELD_ST_W'(s_q) == (n_eff - 1'b1);
  end

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    c_d      = c_q;
    step_d   = step_q;
    bank_d   = bank_q;
    final_d  = final_q;
    res_d    = res_q;
    load_out = 1'b0;
    issue    = 1'b0;
    tbl_wr_o = '0;

    unique case (state_q)
      ST_CLEAR: begin
        tbl_wr_o.en   = 1'b1;
        tbl_wr_o.addr = {s_q, c_q};
        tbl_wr_o.data = '0;
        {s_d, c_d}    = {s_q, c_q} + 1'b1;
        if (&{s_q, c_q}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (action_e'(action_i))
            ACT_SET_TRANS: begin
              tbl_wr_o.en   = from_ok && to_ok && sym_ok;
              tbl_wr_o.addr = {from_idx, SYM_W'(symbol_i)};
              tbl_wr_o.data = to_state_i;
            end
            ACT_MARK_FINAL: begin
              if (from_ok) begin
                final_d[from_idx] = 1'b1;
              end
            end
            ACT_RUN: begin
              s_d    = '0;
              c_d    = '0;
              bank_d = 1'b0;
              if (start_ok) begin
                state_d = ST_INIT;
              end else begin
                res_d   = '0;
                state_d = ST_FINISH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT: begin
        if (last_state) begin
          s_d = '0;
          if (word_length_i == '0) begin
            state_d = ST_READ;
          end else begin
            step_d  = word_length_i;
            state_d = ST_SCAN;
          end
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        c_d   = c_q + 1'b1;
        if (c_q == SYM_LAST) begin
          c_d     = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p2_last_q) begin
          if (last_state) begin
            s_d    = '0;
            bank_d = ~bank_q;
            if (step_q == LEN_W'(1)) begin
              state_d = ST_READ;
            end else begin
              step_d  = step_q - 1'b1;
              state_d = ST_SCAN;
            end
          end else begin
            s_d     = s_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        res_d   = cnt_rd_data_i;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // symbol pipeline: table read, count read, accumulate
  always_comb begin
    p1_v_d    = issue;
    p1_last_d = issue && (c_q == SYM_LAST);
    p2_add_d  = p1_v_q && tgt_ok;
    p2_last_d = p1_v_q && p1_last_q;

    tbl_rd_addr_o = {s_q, c_q};

    if (state_q == ST_READ) begin
      cnt_rd_addr_o = {bank_q, start_idx};
    end else begin
      cnt_rd_addr_o = {bank_q, tgt_idx};
    end

    acc_ctl_o.add  = p2_add_q;
    acc_ctl_o.last = p2_last_q;

    if (state_q == ST_INIT) begin
      cnt_wr_o.en   = 1'b1;
      cnt_wr_o.addr = {bank_q, s_q};
      cnt_wr_o.data = final_q[s_q] ? CNT_W'(1) : '0;
    end else begin
      cnt_wr_o.en   = p2_last_q;
      cnt_wr_o.addr = {~bank_q, s_q};
      cnt_wr_o.data = acc_sum_i;
    end

    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      s_q         <= '0;
      c_q         <= '0;
      step_q      <= '0;
      bank_q      <= 1'b0;
      final_q     <= '0;
      p1_v_q      <= 1'b0;
      p1_last_q   <= 1'b0;
      p2_add_q    <= 1'b0;
      p2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      c_q         <= c_d;
      step_q      <= step_d;
      bank_q      <= bank_d;
      final_q     <= final_d;
      p1_v_q      <= p1_v_d;
      p1_last_q   <= p1_last_d;
      p2_add_q    <= p2_add_d;
      p2_last_q   <= p2_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_out) begin
      out_count_q <= res_q;
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign word_count_o = out_count_q;

endmodule

/* hw/rtl/dfa_word_counter.sv */
// channel  | handshake                    | payload
// ---------+------------------------------+----------------------------------------
// in       | in_valid_i / in_stall_o      | action_i, from_state_i, to_state_i, symbol_i
// out      | out_valid_o / out_stall_i    | word_count_o
// config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// load items are taken while idle; a run reads every symbol of each of n states, n the
//   states in use, once for each of word_length steps, one symbol at a time through
//   the single read port of the transition memory and the shared mod-p adder
// after reset a clearing pass zeroes all 16384 transition memory entries; no item meanwhile
// a result waits in the output register; load items are taken while it waits
module dfa_word_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] from_state_i,
  input  logic [dwc_pkg::FIELD_ST_W-1:0] to_state_i,
  input  logic [dwc_pkg::FIELD_SY_W-1:0] symbol_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dwc_pkg::CNT_W-1:0]      word_count_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dwc_pkg::APB_AW-1:0]     paddr,
  input  logic [dwc_pkg::APB_DW-1:0]     pwdata,
  output logic [dwc_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import dwc_pkg::*;

  logic [LEN_W-1:0]      word_length_q;
  logic [FIELD_ST_W-1:0] start_state_q;
  logic [FIELD_ST_W-1:0] state_count_q;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  tbl_wr_t               tbl_wr;
  logic [TBL_AW-1:0]     tbl_rd_addr;
  logic [FIELD_ST_W-1:0] tbl_rd_data;
  cnt_wr_t               cnt_wr;
  logic [CNT_AW-1:0]     cnt_rd_addr;
  logic [CNT_W-1:0]      cnt_rd_data;
  acc_ctl_t              acc_ctl;
  logic [CNT_W-1:0]      acc_sum;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_length_q <= '0;
      start_state_q <= FIELD_ST_W'(1);
      state_count_q <= FIELD_ST_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WORD_LENGTH: word_length_q <= pwdata[LEN_W-1:0];
        REG_START_STATE: start_state_q <= pwdata[FIELD_ST_W-1:0];
        REG_STATE_COUNT: state_count_q <= pwdata[FIELD_ST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WORD_LENGTH: prdata = APB_DW'(word_length_q);
      REG_START_STATE: prdata = APB_DW'(start_state_q);
      REG_STATE_COUNT: prdata = APB_DW'(state_count_q);
      default:         prdata = '0;
    endcase
  end

  dwc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .from_state_i  (from_state_i),
    .to_state_i    (to_state_i),
    .symbol_i      (symbol_i),
    .word_length_i (word_length_q),
    .start_state_i (start_state_q),
    .state_count_i (state_count_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_count_o  (word_count_o),
    .tbl_wr_o      (tbl_wr),
    .tbl_rd_addr_o (tbl_rd_addr),
    .tbl_rd_data_i (tbl_rd_data),
    .cnt_wr_o      (cnt_wr),
    .cnt_rd_addr_o (cnt_rd_addr),
    .cnt_rd_data_i (cnt_rd_data),
    .acc_ctl_o     (acc_ctl),
    .acc_sum_i     (acc_sum)
  );

  dwc_trans_mem u_trans_mem (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd_data)
  );

  dwc_count_mem u_count_mem (
    .clk_i     (clk_i),
    .wr_i      (cnt_wr),
    .rd_addr_i (cnt_rd_addr),
    .rd_data_o (cnt_rd_data)
  );

  dwc_mod_acc u_mod_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .cnt_i  (cnt_rd_data),
    .sum_o  (acc_sum)
  );

endmodule

/* sim/tb.sv */
module tb;
  import dwc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned STUCK_LIMIT = 200000;
  localparam int unsigned ITEM_TARGET = 1950;

  class dfa_count_tracker;
    bit [FIELD_ST_W-1:0] trans_tbl [MAX_STATES][ALPHABET_SIZE];
    bit                  final_flag [MAX_STATES];
    bit [LEN_W-1:0]      word_len;
    bit [FIELD_ST_W-1:0] start_st;
    bit [FIELD_ST_W-1:0] st_count;
    bit [CNT_W-1:0]      pending_counts [$];
    int                  mismatches;

    function new();
      word_len   = '0;
      start_st   = 7'd1;
      st_count   = 7'd64;
      mismatches = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_WORD_LENGTH: word_len = value[LEN_W-1:0];
        REG_START_STATE: start_st = value[FIELD_ST_W-1:0];
        REG_STATE_COUNT: st_count = value[FIELD_ST_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [CNT_W-1:0] count_words();
      int unsigned     n;
      int unsigned     tgt;
      int unsigned     edges [MAX_STATES][MAX_STATES];
      longint unsigned prev [MAX_STATES];
      longint unsigned nxt [MAX_STATES];
      longint unsigned acc;
      n = (st_count > MAX_STATES) ? MAX_STATES : 32'(st_count);
      if (start_st < 1 || start_st > n) return '0;
      for (int s = 0; s < n; s++) begin
        for (int t = 0; t < n; t++) edges[s][t] = 0;
        for (int c = 0; c < ALPHABET_SIZE; c++) begin
          tgt = 32'(trans_tbl[s][c]);
          if (tgt >= 1 && tgt <= n) edges[s][tgt-1]++;
        end
        prev[s] = final_flag[s] ? 64'd1 : 64'd0;
      end
      for (int step = 0; step < word_len; step++) begin
        for (int s = 0; s < n; s++) begin
          acc = 0;
          for (int t = 0; t < n; t++)
            if (edges[s][t] != 0)
              acc = (acc + 64'(edges[s][t]) * prev[t]) % 64'(PRIME_MOD);
          nxt[s] = acc;
        end
        for (int s = 0; s < n; s++) prev[s] = nxt[s];
      end
      return prev[start_st-1][CNT_W-1:0];
    endfunction

    function void note_item(logic [1:0] act, logic [FIELD_ST_W-1:0] src,
                            logic [FIELD_ST_W-1:0] dst, logic [FIELD_SY_W-1:0] sym);
      case (act)
        ACT_SET_TRANS: begin
          if (src >= 1 && src <= MAX_STATES && dst >= 1 && dst <= MAX_STATES)
            trans_tbl[src-1][sym] = dst;
        end
        ACT_MARK_FINAL: begin
          if (src >= 1 && src <= MAX_STATES) final_flag[src-1] = 1'b1;
        end
        ACT_RUN: pending_counts.push_back(count_words());
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_count(logic [CNT_W-1:0] got);
      bit [CNT_W-1:0] want;
      if (pending_counts.size() == 0) begin
        report($sformatf("word_count %0d with no run pending", got));
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) report($sformatf("word_count %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = '0;
  logic [FIELD_ST_W-1:0] from_state = '0;
  logic [FIELD_ST_W-1:0] to_state = '0;
  logic [FIELD_SY_W-1:0] symbol = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CNT_W-1:0]      word_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  dfa_count_tracker tracker;
  int unsigned      items_sent = 0;
  int unsigned      stuck_cycles = 0;
  int unsigned      stall_left = 0;
  bit               steady = 1'b0;

  dfa_word_counter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .from_state_i (from_state),
    .to_state_i   (to_state),
    .symbol_i     (symbol),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .word_count_o (word_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin : result_side
    int unsigned r;
    if (rst_n && out_valid && !out_stall) tracker.check_count(word_count);
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(20, 200);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] act, logic [FIELD_ST_W-1:0] src,
                           logic [FIELD_ST_W-1:0] dst, logic [FIELD_SY_W-1:0] sym);
    int unsigned r;
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    from_state <= src;
    to_state   <= dst;
    symbol     <= sym;
    do @(posedge clk); while (in_stall);
    tracker.note_item(act, src, dst, sym);
    items_sent++;
  endtask

  task automatic drain_counts();
    in_valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.note_config(idx, value);
  endtask

  task automatic configure(int unsigned len, int unsigned start, int unsigned count);
    drain_counts();
    write_reg(REG_WORD_LENGTH, len);
    write_reg(REG_START_STATE, start);
    write_reg(REG_STATE_COUNT, count);
  endtask

  task automatic random_item(int unsigned n);
    int unsigned r;
    logic [1:0]  act;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_item(ACT_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)));
    end else if (r < 15) begin
      send_item(ACT_MARK_FINAL, 7'($urandom_range(1, n)), 7'($urandom_range(0, 127)),
                8'h00);
    end else if (r < 82) begin
      send_item(ACT_SET_TRANS, 7'($urandom_range(1, n)), 7'($urandom_range(1, n)),
                8'($urandom_range(0, 255)));
    end else if (r < 92) begin
      send_item(ACT_SET_TRANS, 7'($urandom_range(1, n)), 7'($urandom_range(1, MAX_STATES)),
                8'($urandom_range(0, 255)));
    end else begin
      act = 2'($urandom_range(0, 2));
      if (act == ACT_RUN) act = ACT_UNUSED;
      send_item(act, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase();
    int unsigned r;
    int unsigned n_cfg;
    int unsigned n_use;
    int unsigned len;
    int unsigned start;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      n_cfg = $urandom_range(64, 127);
      len   = $urandom_range(0, 1);
    end else if (r < 20) begin
      n_cfg = 1;
      len   = $urandom_range(10, 40);
    end else begin
      n_cfg = $urandom_range(1, 6);
      len   = $urandom_range(0, 8);
    end
    n_use = (n_cfg > MAX_STATES) ? MAX_STATES : n_cfg;
    start = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 127) : $urandom_range(1, n_use);
    configure(len, start, n_cfg);
    steady = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(15, 45)) random_item(n_use);
    steady = 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_RUN, 7'd1, 7'd1, 8'h00);
    send_item(ACT_MARK_FINAL, 7'd1, 7'd0, 8'h00);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    send_item(ACT_SET_TRANS, 7'd1, 7'd1, 8'h00);
    send_item(ACT_SET_TRANS, 7'd1, 7'd64, 8'hff);
    send_item(ACT_SET_TRANS, 7'd64, 7'd1, 8'h55);
    send_item(ACT_SET_TRANS, 7'd1, 7'd2, 8'h00);
    send_item(ACT_SET_TRANS, 7'd0, 7'd1, 8'h01);
    send_item(ACT_SET_TRANS, 7'd65, 7'd1, 8'h01);
    send_item(ACT_SET_TRANS, 7'd1, 7'd0, 8'h02);
    send_item(ACT_SET_TRANS, 7'd127, 7'd127, 8'haa);
    send_item(ACT_MARK_FINAL, 7'd0, 7'd0, 8'h00);
    send_item(ACT_MARK_FINAL, 7'd127, 7'd0, 8'h00);
    send_item(ACT_MARK_FINAL, 7'd64, 7'd0, 8'h00);
    send_item(ACT_UNUSED, 7'd127, 7'd127, 8'hff);
    configure(1, 1, 64);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    configure(2, 64, 127);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    configure(1, 1, 2);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    configure(0, 1, 0);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    configure(3, 0, 5);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);
    configure(65535, 127, 64);
    send_item(ACT_MARK_FINAL, 7'd2, 7'd0, 8'h00);
    send_item(ACT_SET_TRANS, 7'd2, 7'd1, 8'h07);
    configure(3, 2, 2);
    send_item(ACT_RUN, 7'd0, 7'd0, 8'h00);

    while (items_sent < ITEM_TARGET) random_phase();

    in_valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_counts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
